FILE: hdl/rtc_fields_to_epoch_seconds_unit_defines.svh
// Assertion macros shared by the checker of the RTC epoch conversion unit.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef RTC_FIELDS_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH
`define RTC_FIELDS_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFES_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFES_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rfes_pkg.sv
// Shared types and constants of the RTC fields to epoch seconds unit.
// Used by every module of the block; depends on nothing else.
package rfes_pkg;

   // Pipeline stages, in order from the request side.
   localparam int NUM_STAGES = 6;
   localparam int STG_DECODE = 0;
   localparam int STG_PREP   = 1;
   localparam int STG_YEAR   = 2;
   localparam int STG_DAYS   = 3;
   localparam int STG_SCALE  = 4;
   localparam int STG_OUT    = 5;

   // Widths: each intermediate fits its largest value; the epoch wraps modulo 2^33.
   localparam int EPOCH_W = 33;
   localparam int TOD_W   = 20;
   localparam int DAYS_W  = 17;
   localparam int YDAYS_W = 18;
   localparam int MDAYS_W = 13;
   localparam int YOE_W   = 9;
   localparam int MNUM_W  = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_IS_BINARY = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOURS_24       = 1'b1;

   // Calendar constants.
   localparam int DAYS_PER_ERA      = 146097;
   localparam int EPOCH_DAY_OFFSET  = 719468;
   localparam int SECS_PER_DAY      = 86400;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic                  data_is_binary;
      logic                  hours_24;
   } pipe_ctl_type;

   typedef struct packed {
      logic [7:0] second;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } fields_type;

   typedef struct packed {
      logic [7:0]        second;
      logic [7:0]        minute;
      logic [7:0]        hour;
      logic [7:0]        day;
      logic              late_era;
      logic [YOE_W-1:0]  yoe;
      logic [MNUM_W-1:0] month_num;
   } prep_type;

   typedef struct packed {
      logic [TOD_W-1:0]   tod;
      logic [7:0]         day;
      logic               late_era;
      logic [YDAYS_W-1:0] year_days;
      logic [MDAYS_W-1:0] month_days;
   } year_type;

   typedef struct packed {
      logic [TOD_W-1:0]  tod;
      logic [DAYS_W-1:0] days;
   } days_type;

endpackage

FILE: hdl/rfes_field_decode.sv
// First two pipeline stages: BCD decode unless data is binary, then hour format
// conversion and the month/year preparation for the day count. Uses rfes_pkg.
module rfes_field_decode
   import rfes_pkg::*;
(
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  fields_type   raw,
   output prep_type     prep_ff
);

   localparam logic [7:0]       HOUR_NOON     = 8'd12;
   localparam logic [7:0]       HOURS_PER_DAY = 8'd24;
   localparam logic [16:0]      MOD24_RECIP   = 17'd683;
   localparam int               MOD24_SHIFT   = 14;
   localparam logic [YOE_W-1:0] YOE_ERA_WRAP  = 9'd399;

   fields_type        dec_in;
   fields_type        dec_ff;
   prep_type          prep_in;
   logic [7:0]        hour12;
   logic [7:0]        pm_sum;
   logic [16:0]       pm_prod;
   logic [2:0]        pm_quo;
   logic [7:0]        pm_hour;
   logic              early;
   logic [7:0]        month_shift;

   function automatic logic [7:0] bcd_byte(input logic [7:0] b);
      return 8'({4'b0, b[3:0]}) + 8'({4'b0, b[7:4]} * 8'd10);
   endfunction

   // Only bits 6..4 form the tens digit; bit 7 passes through as the PM flag.
   function automatic logic [7:0] bcd_hour(input logic [7:0] b);
      logic [6:0] low;
      low = 7'({3'b0, b[3:0]}) + 7'({4'b0, b[6:4]} * 7'd10);
      return {b[7], low};
   endfunction

   always_comb begin
      if (ctl.data_is_binary) begin
         dec_in = raw;
      end else begin
         dec_in.second = bcd_byte(raw.second);
         dec_in.minute = bcd_byte(raw.minute);
         dec_in.hour   = bcd_hour(raw.hour);
         dec_in.day    = bcd_byte(raw.day);
         dec_in.month  = bcd_byte(raw.month);
         dec_in.year   = bcd_byte(raw.year);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_DECODE]) begin
         dec_ff <= dec_in;
      end
   end

   // 12-hour form: noon and midnight read as 12, so 12 folds to 0 before the
   // PM offset. The wrap at 24 uses a reciprocal multiply, exact below 140.
   always_comb begin
      hour12 = {1'b0, dec_ff.hour[6:0]};
      if (hour12 == HOUR_NOON) begin
         hour12 = '0;
      end
      pm_sum  = hour12 + HOUR_NOON;
      pm_prod = 17'(pm_sum) * MOD24_RECIP;
      pm_quo  = 3'(pm_prod >> MOD24_SHIFT);
      pm_hour = pm_sum - 8'({5'b0, pm_quo} * HOURS_PER_DAY);
   end

   always_comb begin
      prep_in.second = dec_ff.second;
      prep_in.minute = dec_ff.minute;
      prep_in.day    = dec_ff.day;
      if (ctl.hours_24) begin
         prep_in.hour = dec_ff.hour;
      end else if (dec_ff.hour[7]) begin
         prep_in.hour = pm_hour;
      end else begin
         prep_in.hour = hour12;
      end

      // Months are counted from March, so January and February belong to
      // the previous year.
      early       = (dec_ff.month <= 8'd2);
      month_shift = early ? (dec_ff.month + 8'd9) : (dec_ff.month - 8'd3);
      prep_in.month_num = MNUM_W'(16'(month_shift) * 16'd153) + 16'd2;

      // The year is 2000 plus the byte; only January or February of 2000
      // falls back into the previous era, as its last year.
      if ((dec_ff.year == 8'd0) && early) begin
         prep_in.late_era = 1'b0;
         prep_in.yoe      = YOE_ERA_WRAP;
      end else begin
         prep_in.late_era = 1'b1;
         prep_in.yoe      = {1'b0, dec_ff.year} - YOE_W'(early);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_PREP]) begin
         prep_ff <= prep_in;
      end
   end

endmodule

FILE: hdl/rfes_day_count.sv
// Third and fourth pipeline stages: day offsets within the era and the month,
// time of day in seconds, then the day count since the epoch. Uses rfes_pkg.
module rfes_day_count
   import rfes_pkg::*;
(
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  prep_type     prep,
   output days_type     days_ff
);

   localparam logic [31:0] DIV5_RECIP   = 32'd52429;
   localparam int          DIV5_SHIFT   = 18;
   localparam logic [14:0] DIV100_RECIP = 15'd41;
   localparam int          DIV100_SHIFT = 12;
   // Era base with the minus one of the day of month folded in.
   localparam logic [19:0] BASE_LATE  = 20'(5 * DAYS_PER_ERA - EPOCH_DAY_OFFSET - 1);
   localparam logic [19:0] BASE_EARLY = 20'(4 * DAYS_PER_ERA - EPOCH_DAY_OFFSET - 1);

   year_type           year_in;
   year_type           year_ff;
   days_type           days_in;
   logic [31:0]        div5_prod;
   logic [14:0]        div100_prod;
   logic [2:0]         centuries;
   logic [YDAYS_W-1:0] year_lin;
   logic [19:0]        day_sum;

   // Both divisions by constants are reciprocal multiplies that are exact
   // over the value ranges reached here.
   always_comb begin
      div5_prod          = 32'(prep.month_num) * DIV5_RECIP;
      year_in.month_days = MDAYS_W'(div5_prod >> DIV5_SHIFT);

      div100_prod = 15'(prep.yoe) * DIV100_RECIP;
      centuries   = 3'(div100_prod >> DIV100_SHIFT);
      year_lin    = YDAYS_W'(prep.yoe) * YDAYS_W'(365);
      year_in.year_days = year_lin + YDAYS_W'(prep.yoe >> 2) - YDAYS_W'(centuries);

      year_in.tod = TOD_W'(prep.hour) * TOD_W'(3600) + TOD_W'(prep.minute) * TOD_W'(60)
                    + TOD_W'(prep.second);
      year_in.day      = prep.day;
      year_in.late_era = prep.late_era;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_YEAR]) begin
         year_ff <= year_in;
      end
   end

   // The true count always lies in 0 .. 2^17, so modular 20-bit arithmetic
   // with the early era's negative base gives it exactly.
   always_comb begin
      day_sum = (year_ff.late_era ? BASE_LATE : BASE_EARLY) + 20'(year_ff.year_days)
                + 20'(year_ff.month_days) + 20'(year_ff.day);
      days_in.days = day_sum[DAYS_W-1:0];
      days_in.tod  = year_ff.tod;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_DAYS]) begin
         days_ff <= days_in;
      end
   end

endmodule

FILE: hdl/rfes_sec_scale.sv
// Last two pipeline stages: days times seconds per day, then the time of day
// is added; the result is kept modulo 2^33. Uses rfes_pkg.
module rfes_sec_scale
   import rfes_pkg::*;
(
   input  logic               clock,
   input  pipe_ctl_type       ctl,
   input  days_type           days,
   output logic [EPOCH_W-1:0] epoch_ff
);

   logic [EPOCH_W:0]   scale_prod;
   logic [EPOCH_W-1:0] scaled_in;
   logic [EPOCH_W-1:0] scaled_ff;
   logic [TOD_W-1:0]   tod_ff;
   logic [EPOCH_W-1:0] epoch_in;

   always_comb begin
      scale_prod = (EPOCH_W + 1)'(days.days) * (EPOCH_W + 1)'(SECS_PER_DAY);
      scaled_in  = scale_prod[EPOCH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_SCALE]) begin
         scaled_ff <= scaled_in;
         tod_ff    <= days.tod;
      end
   end

   assign epoch_in = scaled_ff + EPOCH_W'(tod_ff);

   always_ff @(posedge clock) begin
      if (ctl.en[STG_OUT]) begin
         epoch_ff <= epoch_in;
      end
   end

endmodule

FILE: hdl/rtc_fields_to_epoch_seconds_unit.sv
// Top level of the RTC fields to epoch seconds unit: configuration registers,
// pipeline valid/enable control and the three datapath modules. Uses rfes_pkg.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  six raw clock bytes
//   rsp_     out        rsp_valid/rsp_stall  33-bit seconds since 1970
//   csr_     in         csr_valid/csr_ready  register index, write bit
//
// Six register stages; a new request is taken every cycle while req_stall is low.
// A stalled result holds in the output stage; empty stages further back keep
// filling, so req_stall rises only when every stage holds a request.
// Reset (synchronous) empties the pipeline and restores BCD, 24-hour mode.
module rtc_fields_to_epoch_seconds_unit
   import rfes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_raw_second,
   input  logic [7:0]             req_raw_minute,
   input  logic [7:0]             req_raw_hour,
   input  logic [7:0]             req_raw_day,
   input  logic [7:0]             req_raw_month,
   input  logic [7:0]             req_raw_year,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [EPOCH_W-1:0]     rsp_epoch_seconds,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata
);

   logic                  cfg_binary_ff;
   logic                  cfg_hours24_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;
   pipe_ctl_type          ctl;
   fields_type            raw;
   prep_type              prep;
   days_type              days;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_binary_ff  <= 1'b0;
         cfg_hours24_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DATA_IS_BINARY: cfg_binary_ff  <= csr_wdata;
            REG_HOURS_24:       cfg_hours24_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   assign ctl.en             = en;
   assign ctl.data_is_binary = cfg_binary_ff;
   assign ctl.hours_24       = cfg_hours24_ff;

   assign raw.second = req_raw_second;
   assign raw.minute = req_raw_minute;
   assign raw.hour   = req_raw_hour;
   assign raw.day    = req_raw_day;
   assign raw.month  = req_raw_month;
   assign raw.year   = req_raw_year;

   rfes_field_decode u_decode (
      .clock   (clock),
      .ctl     (ctl),
      .raw     (raw),
      .prep_ff (prep)
   );

   rfes_day_count u_day_count (
      .clock   (clock),
      .ctl     (ctl),
      .prep    (prep),
      .days_ff (days)
   );

   rfes_sec_scale u_sec_scale (
      .clock    (clock),
      .ctl      (ctl),
      .days     (days),
      .epoch_ff (rsp_epoch_seconds)
   );

endmodule

FILE: hdl/rfes_checker.sv
// Port-level checker for the RTC fields to epoch seconds unit, bound to the
// top level. Uses rfes_pkg and the shared assertion macros.
`include "rtc_fields_to_epoch_seconds_unit_defines.svh"

module rfes_checker
   import rfes_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [EPOCH_W-1:0] rsp_epoch_seconds
);

   localparam int OCC_W = $clog2(NUM_STAGES + 1);

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign occ_in   = occ_ff + OCC_W'(req_take) - OCC_W'(rsp_take);

   // Requests inside the block: accepted but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `RFES_ASSERT_SAME(a_no_stall_when_drained, (!rsp_valid || !rsp_stall), !req_stall, "request stalled while the output side drains")
   `RFES_ASSERT_SAME(a_no_invented_result, rsp_valid, (occ_ff != '0), "result shown with no request in flight")
   `RFES_ASSERT_SAME(a_occupancy_bound, 1'b1, (occ_ff <= OCC_W'(NUM_STAGES)), "more requests in flight than stages")
   `RFES_ASSERT_NEXT(a_rsp_holds, (rsp_valid && rsp_stall), (rsp_valid && $stable(rsp_epoch_seconds)), "stalled result changed")

endmodule

bind rtc_fields_to_epoch_seconds_unit rfes_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_epoch_seconds (rsp_epoch_seconds)
);
